// ----- rtl/dvru_pkg.sv -----
package dvru_pkg;

   localparam int NODE_COUNT = 16;
   localparam int NODE_W     = 4;
   localparam int LINK_W     = 10;
   localparam int ROUTE_W    = 11;

   localparam logic [ROUTE_W-1:0] DELETED_ABOVE = ROUTE_W'(1000);
   localparam logic [ROUTE_W-1:0] COST_MAX      = ROUTE_W'(2047);

   typedef enum logic [1:0] {
      OP_INSTALL = 2'd0,
      OP_HEADER  = 2'd1,
      OP_ENTRY   = 2'd2
   } opcode_type;

   typedef struct packed {
      opcode_type        opcode;
      logic [NODE_W-1:0] peer_node;
      logic [NODE_W-1:0] dest_node;
      logic [LINK_W-1:0] cost_value;
   } item_type;

   typedef struct packed {
      logic [NODE_W-1:0]  next_hop;
      logic [ROUTE_W-1:0] cost;
   } route_type;

   typedef struct packed {
      logic              route_wr;
      logic              link_wr;
      logic [NODE_W-1:0] node;
      route_type         entry;
   } update_type;

   typedef struct packed {
      logic [NODE_W-1:0]  entry_node;
      logic [NODE_W-1:0]  entry_next_hop;
      logic [ROUTE_W-1:0] entry_cost;
      logic               entry_present;
      logic               entry_changed;
   } result_type;

endpackage

// ----- rtl/dvru_route_mem.sv -----
module dvru_route_mem (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [dvru_pkg::NODE_W-1:0] wr_addr,
   input  dvru_pkg::route_type      wr_data,
   input  logic                     rd_en,
   input  logic [dvru_pkg::NODE_W-1:0] rd_addr_a,
   input  logic [dvru_pkg::NODE_W-1:0] rd_addr_b,
   output dvru_pkg::route_type      rd_data_a,
   output dvru_pkg::route_type      rd_data_b
);
   import dvru_pkg::*;

   route_type mem [NODE_COUNT];
   route_type rd_a_ff;
   route_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/dvru_relax.sv -----
module dvru_relax (
   input  dvru_pkg::item_type          item,
   input  logic [dvru_pkg::NODE_W-1:0] self_node,
   input  logic                        peer_valid,
   input  dvru_pkg::route_type         peer_entry,
   input  logic                        dest_valid,
   input  dvru_pkg::route_type         dest_entry,
   input  logic [dvru_pkg::LINK_W-1:0] peer_link_cost,
   output dvru_pkg::update_type        upd,
   output dvru_pkg::result_type        result
);
   import dvru_pkg::*;

   logic [ROUTE_W-1:0] base_cost;
   logic [ROUTE_W:0]   sum_full;
   logic [ROUTE_W-1:0] sum_sat;
   logic               cur_valid;
   route_type          cur_entry;

   // route cost to the peer; a peer without a route counts as zero
   assign base_cost = peer_valid ? peer_entry.cost : '0;
   assign sum_full  = {2'b00, item.cost_value} + {1'b0, base_cost};
   assign sum_sat   = sum_full[ROUTE_W] ? COST_MAX : sum_full[ROUTE_W-1:0];

   always_comb begin
      upd       = '0;
      upd.node  = item.peer_node;
      cur_valid = peer_valid;
      cur_entry = peer_entry;
      case (item.opcode)
         OP_INSTALL: begin
            if (item.peer_node != self_node) begin
               upd.route_wr       = 1'b1;
               upd.link_wr        = 1'b1;
               upd.entry.next_hop = item.peer_node;
               upd.entry.cost     = {1'b0, item.cost_value};
            end
         end
         OP_HEADER: begin
            upd.route_wr       = 1'b1;
            upd.entry.next_hop = peer_valid ? peer_entry.next_hop : item.peer_node;
            upd.entry.cost     = {1'b0, peer_link_cost};
         end
         OP_ENTRY: begin
            upd.node  = item.dest_node;
            cur_valid = dest_valid;
            cur_entry = dest_entry;
            // replace when absent, deleted or strictly dearer, unless the destination is this node
            if (item.dest_node != self_node &&
                (!dest_valid || dest_entry.cost > DELETED_ABOVE ||
                 dest_entry.cost > sum_sat)) begin
               upd.route_wr       = 1'b1;
               upd.entry.next_hop = item.peer_node;
               upd.entry.cost     = sum_sat;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.entry_node    = upd.node;
      result.entry_present = upd.route_wr | cur_valid;
      result.entry_changed = upd.route_wr;
      if (upd.route_wr) begin
         result.entry_next_hop = upd.entry.next_hop;
         result.entry_cost     = upd.entry.cost;
      end else if (cur_valid) begin
         result.entry_next_hop = cur_entry.next_hop;
         result.entry_cost     = cur_entry.cost;
      end else begin
         result.entry_next_hop = '0;
         result.entry_cost     = '0;
      end
   end

endmodule

// ----- rtl/distance_vector_route_update.sv -----
// Distance-vector route table update.
// Input channel req_*: one command per transfer (install neighbor,
// advertisement header, advertisement entry). Result channel rsp_*: exactly
// one result per command, in order, reporting the route entry touched.
// csr_wr_en/csr_wr_data set this router's own node index; write only while
// the block is idle.
// A command taken into the input stage gives its result on rsp_* when it
// commits. Throughput: one command per cycle while req_stall is low. The
// route memory is read at acceptance (peer and destination ports) and written
// at commit; a one-entry bypass covers the write that lands at the same edge
// as the read, so back-to-back commands on the same node work at full rate.
// Reset clears the route valid bits, all link costs, the own node index
// and the pipeline. Next hop and cost storage is not cleared; entries are
// gated by their valid bits.
// When rsp_stall is high while a result is valid the result register holds; one more command can
// be taken into the input stage, after which req_stall rises.
module distance_vector_route_update (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [dvru_pkg::NODE_W-1:0]    csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_opcode,
   input  logic [dvru_pkg::NODE_W-1:0]    req_peer_node,
   input  logic [dvru_pkg::NODE_W-1:0]    req_dest_node,
   input  logic [dvru_pkg::LINK_W-1:0]    req_cost_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [dvru_pkg::NODE_W-1:0]    rsp_entry_node,
   output logic [dvru_pkg::NODE_W-1:0]    rsp_entry_next_hop,
   output logic [dvru_pkg::ROUTE_W-1:0]   rsp_entry_cost,
   output logic                           rsp_entry_present,
   output logic                           rsp_entry_changed
);
   import dvru_pkg::*;

   logic [NODE_W-1:0]  self_node_ff;
   logic [NODE_COUNT-1:0] route_valid_ff;
   logic [LINK_W-1:0]  link_cost_ff [NODE_COUNT];

   logic               s1_valid_ff;
   item_type           item_ff;
   logic               byp_valid_ff;
   logic [NODE_W-1:0]  byp_node_ff;
   route_type          byp_entry_ff;

   logic               rsp_valid_ff;
   result_type         rsp_ff;

   logic               accept;
   logic               advance;
   logic               commit;
   route_type          rd_peer;
   route_type          rd_dest;
   route_type          peer_entry;
   route_type          dest_entry;
   update_type         upd;
   result_type         result;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign commit    = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_node_ff <= '0;
      end else if (csr_wr_en) begin
         self_node_ff <= csr_wr_data;
      end
   end

   dvru_route_mem u_route_mem (
      .clock     (clock),
      .wr_en     (commit && upd.route_wr),
      .wr_addr   (upd.node),
      .wr_data   (upd.entry),
      .rd_en     (accept),
      .rd_addr_a (req_peer_node),
      .rd_addr_b (req_dest_node),
      .rd_data_a (rd_peer),
      .rd_data_b (rd_dest)
   );

   // forward the write that landed at the edge this item was read
   assign peer_entry = (byp_valid_ff && byp_node_ff == item_ff.peer_node) ?
                       byp_entry_ff : rd_peer;
   assign dest_entry = (byp_valid_ff && byp_node_ff == item_ff.dest_node) ?
                       byp_entry_ff : rd_dest;

   dvru_relax u_relax (
      .item           (item_ff),
      .self_node      (self_node_ff),
      .peer_valid     (route_valid_ff[item_ff.peer_node]),
      .peer_entry     (peer_entry),
      .dest_valid     (route_valid_ff[item_ff.dest_node]),
      .dest_entry     (dest_entry),
      .peer_link_cost (link_cost_ff[item_ff.peer_node]),
      .upd            (upd),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         byp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff  <= 1'b1;
            byp_valid_ff <= commit && upd.route_wr;
         end else if (commit) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff      <= {opcode_type'(req_opcode), req_peer_node, req_dest_node,
                          req_cost_value};
         byp_node_ff  <= upd.node;
         byp_entry_ff <= upd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         route_valid_ff <= '0;
         for (int i = 0; i < NODE_COUNT; i++) begin
            link_cost_ff[i] <= '0;
         end
      end else if (commit) begin
         if (upd.route_wr) begin
            route_valid_ff[upd.node] <= 1'b1;
         end
         if (upd.link_wr) begin
            link_cost_ff[upd.node] <= item_ff.cost_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_node     = rsp_ff.entry_node;
   assign rsp_entry_next_hop = rsp_ff.entry_next_hop;
   assign rsp_entry_cost     = rsp_ff.entry_cost;
   assign rsp_entry_present  = rsp_ff.entry_present;
   assign rsp_entry_changed  = rsp_ff.entry_changed;

   a_changed_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.entry_changed |-> rsp_ff.entry_present)
      else $error("changed entry reported as absent");

   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.entry_present |->
         rsp_ff.entry_next_hop == '0 && rsp_ff.entry_cost == '0)
      else $error("absent entry carries nonzero fields");

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      commit && upd.route_wr |=> route_valid_ff[$past(upd.node)])
      else $error("route write left entry invalid");

   a_commit_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed item produced no result");

endmodule
